>>> src/matrix_inverse_3x3_core_defines.svh
// Assertion macros shared by the matrix inverse RTL.
`ifndef MATRIX_INVERSE_3X3_CORE_DEFINES_SVH
`define MATRIX_INVERSE_3X3_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define MI3_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and disabled during reset.
`define MI3_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> src/mi3_pkg.sv
// Shared widths, stage counts and status codes of the 3x3 matrix inverse.
`default_nettype none
package mi3_pkg;
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int ADJ_BITS = 2 * WORD_BITS + 1;
  localparam int LO_BITS = WORD_BITS + 1;
  localparam int PPL_BITS = 2 * WORD_BITS + 2;
  localparam int TERM_BITS = 3 * WORD_BITS + 2;
  localparam int DET_BITS = 3 * WORD_BITS + 3;
  localparam int NUM_BITS = ADJ_BITS + 2 * FRAC_BITS;
  localparam int REM_BITS = DET_BITS + WORD_BITS;
  localparam int DIV_STAGES = WORD_BITS + 4;
  localparam int FRONT_STAGES = 6;
  localparam int PIPE_STAGES = FRONT_STAGES + DIV_STAGES + 1;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_SINGULAR = 2'd1;
  localparam logic [1:0] STATUS_SAT = 2'd2;

  typedef logic signed [WORD_BITS-1:0] word_t;
endpackage
`default_nettype wire

>>> src/mi3_in_if.sv
// Input channel: one 3x3 matrix, column by column, with valid and ready.
`default_nettype none
interface mi3_in_if;
  logic valid;
  logic ready;
  mi3_pkg::word_t col0_row0;
  mi3_pkg::word_t col0_row1;
  mi3_pkg::word_t col0_row2;
  mi3_pkg::word_t col1_row0;
  mi3_pkg::word_t col1_row1;
  mi3_pkg::word_t col1_row2;
  mi3_pkg::word_t col2_row0;
  mi3_pkg::word_t col2_row1;
  mi3_pkg::word_t col2_row2;

  modport source (
    output valid, col0_row0, col0_row1, col0_row2, col1_row0, col1_row1, col1_row2,
           col2_row0, col2_row1, col2_row2,
    input  ready
  );
  modport sink (
    input  valid, col0_row0, col0_row1, col0_row2, col1_row0, col1_row1, col1_row2,
           col2_row0, col2_row1, col2_row2,
    output ready
  );
endinterface
`default_nettype wire

>>> src/mi3_out_if.sv
// Output channel: the inverse matrix and its status, with valid and ready.
`default_nettype none
interface mi3_out_if;
  logic valid;
  logic ready;
  mi3_pkg::word_t inv_col0_row0;
  mi3_pkg::word_t inv_col0_row1;
  mi3_pkg::word_t inv_col0_row2;
  mi3_pkg::word_t inv_col1_row0;
  mi3_pkg::word_t inv_col1_row1;
  mi3_pkg::word_t inv_col1_row2;
  mi3_pkg::word_t inv_col2_row0;
  mi3_pkg::word_t inv_col2_row1;
  mi3_pkg::word_t inv_col2_row2;
  logic [1:0] status;

  modport source (
    output valid, inv_col0_row0, inv_col0_row1, inv_col0_row2, inv_col1_row0,
           inv_col1_row1, inv_col1_row2, inv_col2_row0, inv_col2_row1, inv_col2_row2,
           status,
    input  ready
  );
  modport sink (
    input  valid, inv_col0_row0, inv_col0_row1, inv_col0_row2, inv_col1_row0,
           inv_col1_row1, inv_col1_row2, inv_col2_row0, inv_col2_row1, inv_col2_row2,
           status,
    output ready
  );
endinterface
`default_nettype wire

>>> src/mi3_div_lane.sv
// Pipelined rounding, saturating divider lane, one quotient bit per stage.
`default_nettype none
module mi3_div_lane (
  input  wire logic                                  clk,
  input  wire logic [mi3_pkg::DIV_STAGES-1:0]        en,
  input  wire logic signed [mi3_pkg::NUM_BITS-1:0]   num,
  input  wire logic signed [mi3_pkg::DET_BITS-1:0]   den,
  output mi3_pkg::word_t                             quo,
  output logic                                       sat
);
  localparam int W = mi3_pkg::WORD_BITS;
  localparam int NB = mi3_pkg::NUM_BITS;
  localparam int DB = mi3_pkg::DET_BITS;
  localparam int RB = mi3_pkg::REM_BITS;
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W:0] LIM_NEG = (W+1)'(1) << (W - 1);

  logic [NB-1:0] n0;
  logic [DB-1:0] d0;
  logic          neg0;

  logic [RB-1:0] rs [W+1];
  logic [DB-1:0] ds [W+1];
  logic [W-1:0]  qs [W+1];
  logic          negs [W+1];
  logic          ovfs [W+1];

  logic [W:0]    qr;
  logic          neg_r;
  logic          ovf_r;
  logic          rnd;
  logic [W:0]    lim;
  logic          big;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      n0   <= num[NB-1] ? NB'(-num) : NB'(num);
      d0   <= den[DB-1] ? DB'(-den) : DB'(den);
      neg0 <= num[NB-1] ^ den[DB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      rs[0]   <= RB'(n0);
      ds[0]   <= d0;
      qs[0]   <= '0;
      negs[0] <= neg0;
      ovfs[0] <= RB'(n0) >= (RB'(d0) << W);
    end
  end

  for (genvar j = 0; j < W; j++) begin : g_step
    localparam int K = W - 1 - j;
    logic [RB:0] diff;
    assign diff = {1'b0, rs[j]} - ((RB+1)'(ds[j]) << K);
    always_ff @(posedge clk) begin
      if (en[2+j]) begin
        rs[j+1]   <= diff[RB] ? rs[j] : diff[RB-1:0];
        qs[j+1]   <= {qs[j][W-2:0], ~diff[RB]};
        ds[j+1]   <= ds[j];
        negs[j+1] <= negs[j];
        ovfs[j+1] <= ovfs[j];
      end
    end
  end

  assign rnd = {rs[W][DB-1:0], 1'b0} >= {1'b0, ds[W]};

  always_ff @(posedge clk) begin
    if (en[W+2]) begin
      qr    <= {1'b0, qs[W]} + (W+1)'(rnd);
      neg_r <= negs[W];
      ovf_r <= ovfs[W];
    end
  end

  assign lim = neg_r ? LIM_NEG : LIM_NEG - (W+1)'(1);
  assign big = ovf_r || (qr > lim);

  always_ff @(posedge clk) begin
    if (en[W+3]) begin
      if (big) begin
        quo <= neg_r ? WMIN : WMAX;
      end else begin
        quo <= neg_r ? -qr[W-1:0] : qr[W-1:0];
      end
      sat <= big;
    end
  end
endmodule
`default_nettype wire

>>> src/matrix_inverse_3x3_core.sv
// Streaming 3x3 matrix inverse by the adjugate in signed Q16.16 fixed point.
// One matrix is taken per clock unless a stalled output has backed up to the first stage, and
// each result is offered for transfer from the last of the PIPE_STAGES (43) register stages.
// Most of those stages belong to the nine divider lanes, which resolve one quotient bit per
// stage. The adjugate and the determinant are exact, each output is rounded to nearest
// with ties away from zero, a zero determinant gives zeros with singular status, and
// outputs that overflow are clamped with saturated status. A stalled output holds the
// pipeline back stage by stage, so empty stages still fill while the result waits.
`default_nettype none
`include "matrix_inverse_3x3_core_defines.svh"
module matrix_inverse_3x3_core (
  input wire logic  clk,
  input wire logic  rst,
  mi3_in_if.sink    mat_in,
  mi3_out_if.source mat_out
);
  localparam int F = mi3_pkg::FRAC_BITS;
  localparam int NS = mi3_pkg::PIPE_STAGES;
  localparam int FS = mi3_pkg::FRONT_STAGES;
  localparam int DS = mi3_pkg::DIV_STAGES;

  logic [NS-1:0] v;
  logic [NS-1:0] en;

  mi3_pkg::word_t c [9];
  logic signed [mi3_pkg::PROD_BITS-1:0] pp [9];
  logic signed [mi3_pkg::PROD_BITS-1:0] ps [9];
  mi3_pkg::word_t c0_1 [3];
  logic signed [mi3_pkg::ADJ_BITS-1:0] adj2 [9];
  mi3_pkg::word_t c0_2 [3];
  logic signed [mi3_pkg::PROD_BITS-1:0] ph [3];
  logic signed [mi3_pkg::PPL_BITS-1:0] pl [3];
  logic signed [mi3_pkg::ADJ_BITS-1:0] adj3 [9];
  logic signed [mi3_pkg::TERM_BITS-1:0] term [3];
  logic signed [mi3_pkg::ADJ_BITS-1:0] adj4 [9];
  logic signed [mi3_pkg::DET_BITS-1:0] det;
  logic signed [mi3_pkg::ADJ_BITS-1:0] adj5 [9];
  logic zl [DS];
  mi3_pkg::word_t quo [9];
  logic [8:0] sat;
  mi3_pkg::word_t inv [9];
  logic [1:0] status;

  assign en[NS-1] = !v[NS-1] || mat_out.ready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end
  assign mat_in.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= mat_in.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      c[0] <= mat_in.col0_row0;
      c[1] <= mat_in.col0_row1;
      c[2] <= mat_in.col0_row2;
      c[3] <= mat_in.col1_row0;
      c[4] <= mat_in.col1_row1;
      c[5] <= mat_in.col1_row2;
      c[6] <= mat_in.col2_row0;
      c[7] <= mat_in.col2_row1;
      c[8] <= mat_in.col2_row2;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_row
    localparam int CA = ((i + 1) % 3) * 3;
    localparam int CB = ((i + 2) % 3) * 3;
    for (genvar e = 0; e < 3; e++) begin : g_elem
      localparam int E1 = (e + 1) % 3;
      localparam int E2 = (e + 2) % 3;
      always_ff @(posedge clk) begin
        if (en[1]) begin
          pp[i*3+e] <= c[CA+E1] * c[CB+E2];
          ps[i*3+e] <= c[CA+E2] * c[CB+E1];
        end
        if (en[2]) begin
          adj2[i*3+e] <= mi3_pkg::ADJ_BITS'(pp[i*3+e]) - mi3_pkg::ADJ_BITS'(ps[i*3+e]);
        end
        if (en[3]) begin
          adj3[i*3+e] <= adj2[i*3+e];
        end
        if (en[4]) begin
          adj4[i*3+e] <= adj3[i*3+e];
        end
        if (en[5]) begin
          adj5[i*3+e] <= adj4[i*3+e];
        end
      end
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_det
    always_ff @(posedge clk) begin
      if (en[1]) begin
        c0_1[r] <= c[r];
      end
      if (en[2]) begin
        c0_2[r] <= c0_1[r];
      end
      if (en[3]) begin
        ph[r] <= c0_2[r] * $signed(adj2[r][mi3_pkg::ADJ_BITS-1:mi3_pkg::LO_BITS]);
        pl[r] <= c0_2[r] * $signed({1'b0, adj2[r][mi3_pkg::LO_BITS-1:0]});
      end
      if (en[4]) begin
        term[r] <= (mi3_pkg::TERM_BITS'(ph[r]) <<< mi3_pkg::LO_BITS)
                   + mi3_pkg::TERM_BITS'(pl[r]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      det <= mi3_pkg::DET_BITS'(term[0]) + mi3_pkg::DET_BITS'(term[1])
             + mi3_pkg::DET_BITS'(term[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[FS]) begin
      zl[0] <= (det == '0);
    end
    for (int k = 1; k < DS; k++) begin
      if (en[FS+k]) begin
        zl[k] <= zl[k-1];
      end
    end
  end

  for (genvar col = 0; col < 3; col++) begin : g_col
    for (genvar row = 0; row < 3; row++) begin : g_lane
      logic signed [mi3_pkg::NUM_BITS-1:0] num;
      assign num = mi3_pkg::NUM_BITS'(adj5[row*3+col]) <<< (2 * F);
      mi3_div_lane u_lane (
        .clk (clk),
        .en  (en[FS +: DS]),
        .num (num),
        .den (det),
        .quo (quo[col*3+row]),
        .sat (sat[col*3+row])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      for (int k = 0; k < 9; k++) begin
        inv[k] <= zl[DS-1] ? '0 : quo[k];
      end
      if (zl[DS-1]) begin
        status <= mi3_pkg::STATUS_SINGULAR;
      end else if (|sat) begin
        status <= mi3_pkg::STATUS_SAT;
      end else begin
        status <= mi3_pkg::STATUS_OK;
      end
    end
  end

  assign mat_out.valid = v[NS-1];
  assign mat_out.inv_col0_row0 = inv[0];
  assign mat_out.inv_col0_row1 = inv[1];
  assign mat_out.inv_col0_row2 = inv[2];
  assign mat_out.inv_col1_row0 = inv[3];
  assign mat_out.inv_col1_row1 = inv[4];
  assign mat_out.inv_col1_row2 = inv[5];
  assign mat_out.inv_col2_row0 = inv[6];
  assign mat_out.inv_col2_row1 = inv[7];
  assign mat_out.inv_col2_row2 = inv[8];
  assign mat_out.status = status;

  `MI3_ASSERT_NOW(a_singular_zero, v[NS-1] && status == mi3_pkg::STATUS_SINGULAR, inv[0] == '0 && inv[1] == '0 && inv[2] == '0 && inv[3] == '0 && inv[4] == '0 && inv[5] == '0 && inv[6] == '0 && inv[7] == '0 && inv[8] == '0, "singular result carries nonzero entries")
  `MI3_ASSERT_NOW(a_full_stall, (&v) && !mat_out.ready, !mat_in.ready, "full stalled pipeline still takes a transfer")
  `MI3_ASSERT_NOW(a_out_source, $rose(v[NS-1]), $past(v[NS-2]), "result appeared without an item behind it")
  `MI3_ASSERT_NEXT(a_in_capture, mat_in.valid && mat_in.ready, v[0], "accepted transfer not captured in the first stage")
endmodule
`default_nettype wire
